// ===== design/dlf_pkg.sv =====
// ============================================================================
// dlf_pkg: shared types and constants of the dense layer forward block
// Sizes, field widths, codes and the fixed-point helper functions.
// ============================================================================
package dlf_pkg;

    localparam int MAX_INPUTS  = 64;
    localparam int MAX_NEURONS = 16;

    localparam int IDX_W      = $clog2(MAX_INPUTS);
    localparam int NRN_W      = $clog2(MAX_NEURONS);
    localparam int WMEM_AW    = IDX_W + NRN_W;
    localparam int WMEM_DEPTH = MAX_INPUTS * MAX_NEURONS;

    localparam int VAL_W  = 16;
    localparam int PROD_W = 2 * VAL_W;
    localparam int ACC_W  = 40;
    localparam int FRAC_W = 12;

    localparam int IN_CNT_W  = 7;
    localparam int NRN_CNT_W = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 7;

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;

    localparam logic [1:0] MODE_WEIGHT = 2'd0;
    localparam logic [1:0] MODE_BIAS   = 2'd1;
    localparam logic [1:0] MODE_ELEM   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEURON_COUNT = 1'b1;

    // One input element on its way down the row of cells.
    typedef struct packed {
        logic                    valid;
        logic                    start;
        logic signed [VAL_W-1:0] x;
    } token_t;

    // Controls from the sequencer to the row of cells.
    typedef struct packed {
        token_t                  tok;
        logic                    bias_we;
        logic [NRN_W-1:0]        bias_sel;
        logic signed [VAL_W-1:0] bias_val;
        logic                    shift;
    } cell_ctrl_t;

    // Saturate a sum that has one guard bit to the accumulator range.
    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] s);
        logic signed [ACC_W-1:0] r;
        if (s[ACC_W] != s[ACC_W-1])
        begin
            r = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            r = s[ACC_W-1:0];
        end
        return r;
    endfunction

    // Arithmetic shift right by the fraction width, then saturate to a value.
    function automatic logic signed [VAL_W-1:0] finish(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-FRAC_W-1:0] q;
        logic signed [VAL_W-1:0]        r;
        q = acc[ACC_W-1:FRAC_W];
        if (q[ACC_W-FRAC_W-1:VAL_W-1] == '0 || q[ACC_W-FRAC_W-1:VAL_W-1] == '1)
        begin
            r = q[VAL_W-1:0];
        end
        else
        begin
            r = q[ACC_W-FRAC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// ===== design/dense_layer_forward.sv =====
// ============================================================================
// dense_layer_forward: fully connected layer, forward pass, Q4.12
// A row of neuron cells fed by a sequencer that owns the weight memory.
// ============================================================================
//
//  Channel  Ports                          Beat carries
//  -------  -----------------------------  ------------------------------------
//  s        s_tvalid s_tready s_tdata      load weight, load bias, or element
//           s_tuser
//  m        m_tvalid m_tready m_tdata      one neuron result
//           m_tlast
//  cfg      cfg_we cfg_index cfg_data      input_count, neuron_count
//
//  A weight or bias load leaves s_tready high. An input element holds
//  s_tready low after its beat while the weight memory is read once per
//  cell over the 16 cells of the row and the multiply and accumulate
//  stages of the last cell finish, so no element is taken until the last
//  one is through. After the last element of a row the accumulators shift
//  out of the row one per result beat, so a row ends with neuron_count
//  (clamped to 1..16) more beats, paced by m_tready. Reset clears the biases,
//  the accumulators and the element position; weights hold nothing until loaded.
//
module dense_layer_forward (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // input_index [5:0], neuron_index [9:6], value [25:10], zero [31:26]
    input  logic [dlf_pkg::S_TDATA_W-1:0] s_tdata,
    // mode [1:0]
    input  logic [dlf_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // out_neuron [3:0], activation [19:4], zero [23:20]
    output logic [dlf_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                         m_tlast,
    input  logic                         cfg_we,
    input  logic [dlf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dlf_pkg::CFG_W-1:0]     cfg_data
);
    import dlf_pkg::*;

    cell_ctrl_t              ctrl;
    logic signed [VAL_W-1:0] weight;
    logic [NRN_CNT_W-1:0]    nc_eff;
    token_t                  tok_chain [MAX_NEURONS+1];
    logic signed [ACC_W-1:0] acc_chain [MAX_NEURONS+1];

    dlf_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctrl      (ctrl),
        .weight    (weight),
        .nc_eff    (nc_eff),
        .head_acc  (acc_chain[0])
    );

    assign tok_chain[0]           = ctrl.tok;
    assign acc_chain[MAX_NEURONS] = '0;

    for (genvar k = 0; k < MAX_NEURONS; k++)
    begin : g_cell
        logic active;
        logic bias_we;

        assign active  = NRN_CNT_W'(k) < nc_eff;
        assign bias_we = ctrl.bias_we && (ctrl.bias_sel == NRN_W'(k));

        dlf_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .tok_in   (tok_chain[k]),
            .tok_out  (tok_chain[k+1]),
            .weight   (weight),
            .active   (active),
            .bias_we  (bias_we),
            .bias_val (ctrl.bias_val),
            .shift    (ctrl.shift),
            .acc_in   (acc_chain[k+1]),
            .acc_out  (acc_chain[k])
        );
    end

endmodule

// ===== design/dlf_cell.sv =====
// ============================================================================
// dlf_cell: one neuron of the layer
// Holds the neuron's bias and accumulator, multiplies the passing element by
// its weight and hands the element on to the next cell in the next cycle.
// ============================================================================
module dlf_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dlf_pkg::token_t                   tok_in,
    output dlf_pkg::token_t                   tok_out,
    input  logic signed [dlf_pkg::VAL_W-1:0]  weight,
    input  logic                              active,
    input  logic                              bias_we,
    input  logic signed [dlf_pkg::VAL_W-1:0]  bias_val,
    input  logic                              shift,
    input  logic signed [dlf_pkg::ACC_W-1:0]  acc_in,
    output logic signed [dlf_pkg::ACC_W-1:0]  acc_out
);
    import dlf_pkg::*;

    token_t                   tok_reg;
    logic signed [VAL_W-1:0]  bias_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     pv_reg;
    logic                     pact_reg;
    logic                     pstart_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  base;
    logic signed [ACC_W-1:0]  addend;
    logic signed [ACC_W:0]    sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg    <= '0;
            bias_reg   <= '0;
            pv_reg     <= 1'b0;
            pact_reg   <= 1'b0;
            pstart_reg <= 1'b0;
            acc_reg    <= '0;
        end
        else
        begin
            tok_reg    <= tok_in;
            pv_reg     <= tok_reg.valid;
            pact_reg   <= active;
            pstart_reg <= tok_reg.start;
            acc_reg    <= acc_next;
            if (bias_we)
            begin
                bias_reg <= bias_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(tok_reg.x) * PROD_W'(weight);
    end

    // The first element of a row starts from the bias, aligned to the
    // accumulator's fraction. Every cell is preset, active or not.
    always_comb
    begin
        base   = pstart_reg ? ACC_W'(signed'({bias_reg, {FRAC_W{1'b0}}})) : acc_reg;
        addend = pact_reg ? ACC_W'(prod_reg) : '0;
        sum    = (ACC_W+1)'(base) + (ACC_W+1)'(addend);
        if (shift)
        begin
            acc_next = acc_in;
        end
        else if (pv_reg)
        begin
            acc_next = sat_acc(sum);
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    assign tok_out = tok_reg;
    assign acc_out = acc_reg;

endmodule

// ===== design/dlf_seq.sv =====
// ============================================================================
// dlf_seq: sequencer, weight memory and result stage
// Takes input beats and configuration writes, sweeps the weight memory
// along the row of cells and drains the accumulators into the result beats.
// ============================================================================
module dlf_seq (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [dlf_pkg::S_TDATA_W-1:0]         s_tdata,
    input  logic [dlf_pkg::S_TUSER_W-1:0]         s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [dlf_pkg::M_TDATA_W-1:0]         m_tdata,
    output logic                                  m_tlast,
    input  logic                                  cfg_we,
    input  logic [dlf_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [dlf_pkg::CFG_W-1:0]             cfg_data,
    output dlf_pkg::cell_ctrl_t                   ctrl,
    output logic signed [dlf_pkg::VAL_W-1:0]      weight,
    output logic [dlf_pkg::NRN_CNT_W-1:0]         nc_eff,
    input  logic signed [dlf_pkg::ACC_W-1:0]      head_acc
);
    import dlf_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SWEEP  = 4'b0010,
        ST_SETTLE = 4'b0100,
        ST_DRAIN  = 4'b1000
    } state_t;

    // Last value of the settle counter: settling ends once the last cell has accumulated.
    localparam logic [NRN_W-1:0] SETTLE_LAST = NRN_W'(1);

    state_t                  state_reg, state_next;
    logic [NRN_W-1:0]        cnt_reg, cnt_next;
    logic [IDX_W-1:0]        pos_reg, pos_next;
    logic [IDX_W-1:0]        elem_pos_reg;
    logic signed [VAL_W-1:0] x_hold_reg;
    logic                    start_hold_reg;
    logic                    row_last_reg;
    logic [IN_CNT_W-1:0]     input_count_reg;
    logic [NRN_CNT_W-1:0]    neuron_count_reg;
    logic [IN_CNT_W-1:0]     in_eff;
    logic                    out_valid_reg;
    logic [NRN_W-1:0]        out_neuron_reg;
    logic signed [VAL_W-1:0] activation_reg;
    logic                    row_end_reg;

    logic signed [VAL_W-1:0] wmem [WMEM_DEPTH];
    logic signed [VAL_W-1:0] weight_reg;

    logic [1:0]              mode;
    logic [IDX_W-1:0]        input_index;
    logic [NRN_W-1:0]        neuron_index;
    logic signed [VAL_W-1:0] value;
    logic                    accept;
    logic                    elem_row_last;
    logic                    move;
    logic                    drain_last;

    assign mode         = s_tuser;
    assign input_index  = s_tdata[IDX_W-1:0];
    assign neuron_index = s_tdata[IDX_W+NRN_W-1:IDX_W];
    assign value        = s_tdata[IDX_W+NRN_W+VAL_W-1:IDX_W+NRN_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        if (input_count_reg == '0)
        begin
            in_eff = IN_CNT_W'(1);
        end
        else if (input_count_reg > IN_CNT_W'(MAX_INPUTS))
        begin
            in_eff = IN_CNT_W'(MAX_INPUTS);
        end
        else
        begin
            in_eff = input_count_reg;
        end
        if (neuron_count_reg == '0)
        begin
            nc_eff = NRN_CNT_W'(1);
        end
        else if (neuron_count_reg > NRN_CNT_W'(MAX_NEURONS))
        begin
            nc_eff = NRN_CNT_W'(MAX_NEURONS);
        end
        else
        begin
            nc_eff = neuron_count_reg;
        end
    end

    assign elem_row_last = (IN_CNT_W'(pos_reg) + IN_CNT_W'(1)) >= in_eff;
    assign move          = (state_reg == ST_DRAIN) && (!out_valid_reg || m_tready);
    assign drain_last    = (NRN_CNT_W'(cnt_reg) + NRN_CNT_W'(1)) == nc_eff;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && mode == MODE_ELEM)
                begin
                    state_next = ST_SWEEP;
                    cnt_next   = '0;
                    pos_next   = elem_row_last ? '0 : pos_reg + IDX_W'(1);
                end
            end
            ST_SWEEP:
            begin
                cnt_next = cnt_reg + NRN_W'(1);
                if (cnt_reg == NRN_W'(MAX_NEURONS - 1))
                begin
                    state_next = ST_SETTLE;
                    cnt_next   = '0;
                end
            end
            ST_SETTLE:
            begin
                cnt_next = cnt_reg + NRN_W'(1);
                if (cnt_reg == SETTLE_LAST)
                begin
                    state_next = row_last_reg ? ST_DRAIN : ST_IDLE;
                    cnt_next   = '0;
                end
            end
            ST_DRAIN:
            begin
                if (move)
                begin
                    cnt_next = cnt_reg + NRN_W'(1);
                    if (drain_last)
                    begin
                        state_next = ST_IDLE;
                        cnt_next   = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            pos_reg          <= '0;
            input_count_reg  <= IN_CNT_W'(MAX_INPUTS);
            neuron_count_reg <= NRN_CNT_W'(MAX_NEURONS);
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pos_reg   <= pos_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_INPUT_COUNT:  input_count_reg  <= cfg_data;
                    CFG_NEURON_COUNT: neuron_count_reg <= cfg_data[NRN_CNT_W-1:0];
                    default:          ;
                endcase
            end
            if (move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && mode == MODE_ELEM)
        begin
            x_hold_reg     <= value;
            start_hold_reg <= (pos_reg == '0);
            elem_pos_reg   <= pos_reg;
            row_last_reg   <= elem_row_last;
        end
        if (move)
        begin
            out_neuron_reg <= cnt_reg;
            activation_reg <= finish(head_acc);
            row_end_reg    <= drain_last;
        end
    end

    // Weight memory: written by weight loads, read one neuron a cycle in the
    // sweep so that the data meets the element as it passes each cell.
    always_ff @(posedge clk)
    begin
        if (accept && mode == MODE_WEIGHT)
        begin
            wmem[{input_index, neuron_index}] <= value;
        end
        weight_reg <= wmem[{elem_pos_reg, cnt_reg}];
    end

    assign weight = weight_reg;

    always_comb
    begin
        ctrl.tok.valid = (state_reg == ST_SWEEP) && (cnt_reg == '0);
        ctrl.tok.start = start_hold_reg;
        ctrl.tok.x     = x_hold_reg;
        ctrl.bias_we   = accept && (mode == MODE_BIAS);
        ctrl.bias_sel  = neuron_index;
        ctrl.bias_val  = value;
        ctrl.shift     = move;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-NRN_W-VAL_W){1'b0}}, activation_reg, out_neuron_reg};
    assign m_tlast  = row_end_reg;

endmodule
